### sv/lrrb_pkg.sv
// Shared types and constants of the log record ring buffer.
package lrrb_pkg;
  localparam int DEPTH = 256;
  localparam int MAX_RECORD = 64;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;
  localparam int QDEPTH = 2;

  localparam logic [2:0] ST_STORED     = 3'd0;
  localparam logic [2:0] ST_FILTERED   = 3'd1;
  localparam logic [2:0] ST_NO_SPACE   = 3'd2;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
  localparam logic [2:0] ST_POPPED     = 3'd4;
  localparam logic [2:0] ST_EMPTY      = 3'd5;
  localparam logic [2:0] ST_TOO_BIG    = 3'd6;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [0:0] REG_LEVEL_THRESHOLD = 1'd0;
  localparam logic [0:0] REG_OVERWRITE_OLD   = 1'd1;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
    logic [2:0] level;
    logic [15:0] budget;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic [2:0] status;
  } res_t;

  typedef struct packed {
    logic [7:0] index;
    logic [7:0] data;
  } cfg_t;
endpackage

### sv/lrrb_if.sv
// Valid/ready channel interfaces.
interface lrrb_req_if;
  logic valid;
  logic ready;
  lrrb_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lrrb_res_if;
  logic valid;
  logic ready;
  lrrb_pkg::res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lrrb_cfg_if;
  logic valid;
  logic ready;
  lrrb_pkg::cfg_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### sv/lrrb_front.sv
// Front end: accepts requests into a short queue.
module lrrb_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lrrb_pkg::req_t in_req,
  output logic           q_valid,
  input  logic           q_take,
  output lrrb_pkg::req_t q_req
);
  lrrb_pkg::req_t q_r [lrrb_pkg::QDEPTH];
  logic [1:0] cnt_r, cnt_nxt;
  logic rd_r, wr_r;
  logic push, pop;

  assign in_ready = (cnt_r != 2'(lrrb_pkg::QDEPTH));
  assign push = in_valid && in_ready;
  assign pop = q_take && q_valid;
  assign q_valid = (cnt_r != 2'd0);
  assign q_req = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= in_req;
  end
endmodule

### sv/lrrb_back.sv
// Back end: ring store, push classification, eviction and pop sequencing.
module lrrb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_take,
  input  lrrb_pkg::req_t q_req,
  input  logic [2:0]     level_threshold,
  input  logic           overwrite_old,
  output logic           out_valid,
  input  logic           out_ready,
  output lrrb_pkg::res_t out_res
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVRD   = 3'd1;
  localparam logic [2:0] S_EVCHK  = 3'd2;
  localparam logic [2:0] S_POPRD  = 3'd3;
  localparam logic [2:0] S_POPCHK = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;
  localparam logic [2:0] S_EMITW  = 3'd6;

  localparam int AW = lrrb_pkg::AW;
  localparam int CW = lrrb_pkg::CW;

  logic [7:0] mem [lrrb_pkg::DEPTH];
  logic [7:0] rdata_r;
  logic [AW-1:0] raddr;
  logic ren;
  logic wen;
  logic [AW-1:0] waddr;
  logic [7:0] wdata;

  logic [2:0] st_r, st_nxt;
  logic [AW-1:0] wi_r, wi_nxt, ri_r, ri_nxt;
  logic [CW-1:0] sb_r, sb_nxt;
  logic [7:0] left_r, left_nxt, plen_r, plen_nxt;
  logic drop_r, drop_nxt;
  logic [2:0] dst_r, dst_nxt;
  logic [7:0] cnt_r, cnt_nxt;   // pop bytes remaining
  logic [7:0] nlen_r, nlen_nxt; // pending new length during eviction
  logic [15:0] bud_r, bud_nxt;
  logic ov_r, ov_nxt;
  lrrb_pkg::res_t ov_res_r, ov_res_nxt;
  logic [CW-1:0] rlen;
  logic [CW:0] fitsum;

  assign out_valid = ov_r;
  assign out_res = ov_res_r;

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    if (ren) rdata_r <= mem[raddr];
  end

  always_comb begin
    st_nxt = st_r; wi_nxt = wi_r; ri_nxt = ri_r; sb_nxt = sb_r;
    left_nxt = left_r; plen_nxt = plen_r; drop_nxt = drop_r; dst_nxt = dst_r;
    cnt_nxt = cnt_r; nlen_nxt = nlen_r; bud_nxt = bud_r;
    ov_nxt = ov_r && !out_ready; ov_res_nxt = ov_res_r;
    q_take = 1'b0; wen = 1'b0; waddr = wi_r; wdata = q_req.data_byte;
    ren = 1'b0; raddr = ri_r;
    rlen = '0; fitsum = '0;
    unique case (st_r)
      S_IDLE: begin
        if (q_valid && !ov_nxt) begin
          if (q_req.command == lrrb_pkg::CMD_PUSH) begin
            ov_res_nxt.out_byte = '0;
            ov_res_nxt.last = 1'b1;
            fitsum = {1'b0, sb_r} + (CW+1)'(q_req.data_byte);
            if (left_r != 8'd0) begin
              q_take = 1'b1; ov_nxt = 1'b1;
              left_nxt = left_r - 8'd1;
              if (drop_r) begin
                if (left_r == 8'd1) drop_nxt = 1'b0;
                ov_res_nxt.status = dst_r;
              end else begin
                wen = 1'b1; wi_nxt = wi_r + AW'(1);
                if (left_r == 8'd1) sb_nxt = sb_r + CW'(plen_r);
                ov_res_nxt.status = lrrb_pkg::ST_STORED;
              end
            end else if (q_req.data_byte == 8'd0 ||
                         q_req.data_byte > 8'(lrrb_pkg::MAX_RECORD)) begin
              q_take = 1'b1; ov_nxt = 1'b1;
              ov_res_nxt.status = lrrb_pkg::ST_BAD_LENGTH;
            end else if (q_req.level < level_threshold) begin
              q_take = 1'b1; ov_nxt = 1'b1;
              dst_nxt = lrrb_pkg::ST_FILTERED;
              left_nxt = q_req.data_byte - 8'd1;
              drop_nxt = (q_req.data_byte > 8'd1);
              ov_res_nxt.status = lrrb_pkg::ST_FILTERED;
            end else if (fitsum > (CW+1)'(lrrb_pkg::DEPTH)) begin
              if (overwrite_old) begin
                // hold the request; walk oldest records out first
                nlen_nxt = q_req.data_byte;
                ren = 1'b1;
                st_nxt = S_EVRD;
              end else begin
                q_take = 1'b1; ov_nxt = 1'b1;
                dst_nxt = lrrb_pkg::ST_NO_SPACE;
                left_nxt = q_req.data_byte - 8'd1;
                drop_nxt = (q_req.data_byte > 8'd1);
                ov_res_nxt.status = lrrb_pkg::ST_NO_SPACE;
              end
            end else begin
              q_take = 1'b1; ov_nxt = 1'b1;
              wen = 1'b1; wi_nxt = wi_r + AW'(1);
              plen_nxt = q_req.data_byte;
              left_nxt = q_req.data_byte - 8'd1;
              drop_nxt = 1'b0;
              if (q_req.data_byte == 8'd1) sb_nxt = sb_r + CW'(1);
              ov_res_nxt.status = lrrb_pkg::ST_STORED;
            end
          end else begin
            q_take = 1'b1;
            bud_nxt = q_req.budget;
            if (sb_r == '0) begin
              ov_nxt = 1'b1;
              ov_res_nxt = '{out_byte: 8'd0, last: 1'b1, status: lrrb_pkg::ST_EMPTY};
            end else begin
              ren = 1'b1;
              st_nxt = S_POPRD;
            end
          end
        end
      end
      S_EVRD: st_nxt = S_EVCHK;
      S_EVCHK: begin
        rlen = CW'(rdata_r);
        if (rdata_r == 8'd0 || CW'(rdata_r) > sb_r) rlen = sb_r;
        sb_nxt = sb_r - rlen;
        ri_nxt = ri_r + AW'(rlen);
        fitsum = {1'b0, sb_nxt} + (CW+1)'(nlen_r);
        if (fitsum > (CW+1)'(lrrb_pkg::DEPTH) && sb_nxt != '0) begin
          ren = 1'b1; raddr = ri_nxt;
          st_nxt = S_EVRD;
        end else begin
          st_nxt = S_IDLE; // store path retries the held length byte
        end
      end
      S_POPRD: st_nxt = S_POPCHK;
      S_POPCHK: begin
        rlen = CW'(rdata_r);
        if (rdata_r == 8'd0 || CW'(rdata_r) > sb_r) rlen = sb_r;
        if (rlen > CW'(lrrb_pkg::MAX_RECORD)) rlen = CW'(lrrb_pkg::MAX_RECORD);
        if (16'(rlen) > bud_r) begin
          ov_nxt = 1'b1;
          ov_res_nxt = '{out_byte: 8'd0, last: 1'b1, status: lrrb_pkg::ST_TOO_BIG};
          st_nxt = S_IDLE;
        end else begin
          cnt_nxt = 8'(rlen);
          ren = 1'b1;
          st_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // data for ri_r is registered; place it once the output is free
        if (!ov_nxt) begin
          ov_nxt = 1'b1;
          ov_res_nxt = '{out_byte: rdata_r, last: (cnt_r == 8'd1),
                         status: lrrb_pkg::ST_POPPED};
          ri_nxt = ri_r + AW'(1);
          cnt_nxt = cnt_r - 8'd1;
          sb_nxt = sb_r - CW'(1);
          if (cnt_r == 8'd1) begin
            if (sb_nxt == '0 && (left_r == 8'd0 || drop_r)) begin
              ri_nxt = '0; wi_nxt = '0;
            end
            st_nxt = S_IDLE;
          end else begin
            ren = 1'b1; raddr = ri_nxt;
            st_nxt = S_EMITW;
          end
        end
      end
      S_EMITW: st_nxt = S_EMIT;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; wi_r <= '0; ri_r <= '0; sb_r <= '0;
      left_r <= '0; plen_r <= '0; drop_r <= 1'b0; dst_r <= '0;
      cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; wi_r <= wi_nxt; ri_r <= ri_nxt; sb_r <= sb_nxt;
      left_r <= left_nxt; plen_r <= plen_nxt; drop_r <= drop_nxt; dst_r <= dst_nxt;
      cnt_r <= cnt_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nlen_r <= nlen_nxt;
    bud_r <= bud_nxt;
    ov_res_r <= ov_res_nxt;
  end
endmodule

### sv/log_record_ring_buffer.sv
// Log record ring buffer: a 256-byte ring of variable-length records. A push
// request is handled in the back end's idle state; a pop reads the length (POPRD,
// POPCHK), then emits bytes via EMIT/EMITW, paced by the single registered read
// port of the ring memory; eviction reads and checks each oldest record (EVRD,
// EVCHK). A two-entry request queue lets requests arrive while the back end works.
module log_record_ring_buffer (
  input logic clk,
  input logic rst_n,
  lrrb_req_if.sink   in_ch,
  lrrb_res_if.source out_ch,
  lrrb_cfg_if.sink   cfg_ch
);
  logic [2:0] thr_r;
  logic ovw_r;
  logic q_valid, q_take;
  lrrb_pkg::req_t q_req;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 3'd1;
      ovw_r <= 1'b1;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.payload.index == 8'(lrrb_pkg::REG_LEVEL_THRESHOLD))
        thr_r <= cfg_ch.payload.data[2:0];
      else if (cfg_ch.payload.index == 8'(lrrb_pkg::REG_OVERWRITE_OLD))
        ovw_r <= cfg_ch.payload.data[0];
    end
  end

  lrrb_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_req(in_ch.payload),
    .q_valid, .q_take, .q_req
  );

  lrrb_back u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_req,
    .level_threshold(thr_r), .overwrite_old(ovw_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(out_ch.payload)
  );
endmodule

### sv/lrrb_checker.sv
// Port-level checker for the log record ring buffer, bound to the top level.
module lrrb_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input lrrb_pkg::res_t out_res
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("result changed while stalled");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res.status <= lrrb_pkg::ST_TOO_BIG)
    else $error("bad status code");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.status != lrrb_pkg::ST_POPPED |-> out_res.last && out_res.out_byte == 8'd0)
    else $error("non-pop result must be single and zero");
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_res.status == lrrb_pkg::ST_POPPED && !out_res.last
    |=> !(out_valid && out_res.status != lrrb_pkg::ST_POPPED))
    else $error("pop record interrupted");
endmodule

bind log_record_ring_buffer lrrb_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_res(out_ch.payload)
);

### sim/log_record_ring_buffer_tb.sv
// Testbench for the log record ring buffer: directed and random record traffic checked against a predictor.
module log_record_ring_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CFG_IDX_UNUSED = 8'd2;
  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lrrb_req_if in_ch();
  lrrb_res_if out_ch();
  lrrb_cfg_if cfg_ch();

  log_record_ring_buffer dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #2 clk = ~clk;

  // Predictor image of the ring and its pointers.
  logic [7:0] ring_img [lrrb_pkg::DEPTH];
  int unsigned wr_ptr, rd_ptr, held_bytes, bytes_to_go, open_len;
  bit skipping;
  logic [2:0] skip_status;
  logic [2:0] level_floor;
  bit evict_on_full;

  lrrb_pkg::req_t pending_reqs[$];
  lrrb_pkg::res_t expected_results[$];
  int unsigned send_idle_pct, recv_stall_pct;
  int errors;
  int unsigned cycles;
  bit req_taken;

  function automatic void clear_model();
    foreach (ring_img[i]) ring_img[i] = 8'd0;
    wr_ptr = 0; rd_ptr = 0; held_bytes = 0; bytes_to_go = 0; open_len = 0;
    skipping = 1'b0; skip_status = lrrb_pkg::ST_STORED;
    level_floor = 3'd1; evict_on_full = 1'b1;
  endfunction

  function automatic void put_result(logic [7:0] b, logic l, logic [2:0] s);
    lrrb_pkg::res_t r;
    r.out_byte = b; r.last = l; r.status = s;
    expected_results.push_back(r);
  endfunction

  function automatic void evict_oldest(int unsigned len);
    int unsigned guard, oldest;
    guard = 0;
    while (held_bytes + len > lrrb_pkg::DEPTH && held_bytes > 0 &&
           guard < lrrb_pkg::DEPTH) begin
      oldest = ring_img[rd_ptr];
      if (oldest == 0 || oldest > held_bytes) oldest = held_bytes;
      held_bytes -= oldest;
      rd_ptr = (rd_ptr + oldest) % lrrb_pkg::DEPTH;
      guard++;
    end
  endfunction

  function automatic logic [2:0] push_record_byte(logic [7:0] b, logic [2:0] lvl);
    logic [2:0] st;
    if (bytes_to_go != 0) begin
      bytes_to_go--;
      if (skipping) begin
        if (bytes_to_go == 0) skipping = 1'b0;
        return skip_status;
      end
      ring_img[wr_ptr] = b;
      wr_ptr = (wr_ptr + 1) % lrrb_pkg::DEPTH;
      if (bytes_to_go == 0) held_bytes += open_len;
      return lrrb_pkg::ST_STORED;
    end
    if (b == 0 || b > lrrb_pkg::MAX_RECORD) return lrrb_pkg::ST_BAD_LENGTH;
    if (lvl < level_floor || held_bytes + b > lrrb_pkg::DEPTH) begin
      if (lvl >= level_floor && evict_on_full) begin
        evict_oldest(b);
      end else begin
        st = (lvl < level_floor) ? lrrb_pkg::ST_FILTERED : lrrb_pkg::ST_NO_SPACE;
        skip_status = st;
        bytes_to_go = b - 1;
        skipping = (b > 1);
        return st;
      end
    end
    ring_img[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1) % lrrb_pkg::DEPTH;
    open_len = b;
    bytes_to_go = b - 1;
    skipping = 1'b0;
    if (bytes_to_go == 0) held_bytes += b;
    return lrrb_pkg::ST_STORED;
  endfunction

  function automatic void pop_oldest_record(logic [15:0] budget);
    int unsigned len;
    if (held_bytes == 0) begin
      put_result(8'd0, 1'b1, lrrb_pkg::ST_EMPTY);
      return;
    end
    len = ring_img[rd_ptr];
    if (len == 0 || len > held_bytes) len = held_bytes;
    if (len > lrrb_pkg::MAX_RECORD) len = lrrb_pkg::MAX_RECORD;
    if (len > budget) begin
      put_result(8'd0, 1'b1, lrrb_pkg::ST_TOO_BIG);
      return;
    end
    for (int unsigned i = 0; i < len; i++) begin
      put_result(ring_img[rd_ptr], (i + 1 == len), lrrb_pkg::ST_POPPED);
      rd_ptr = (rd_ptr + 1) % lrrb_pkg::DEPTH;
    end
    held_bytes -= len;
    if (held_bytes == 0 && (bytes_to_go == 0 || skipping)) begin
      rd_ptr = 0;
      wr_ptr = 0;
    end
  endfunction

  function automatic void predict_request(lrrb_pkg::req_t r);
    if (r.command == lrrb_pkg::CMD_PUSH)
      put_result(8'd0, 1'b1, push_record_byte(r.data_byte, r.level));
    else pop_oldest_record(r.budget);
  endfunction

  // Stimulus builders.
  function automatic void queue_push(logic [7:0] b, logic [2:0] lvl);
    lrrb_pkg::req_t r;
    r.command = lrrb_pkg::CMD_PUSH; r.data_byte = b; r.level = lvl;
    r.budget = 16'($urandom);
    pending_reqs.push_back(r);
  endfunction

  function automatic void queue_pop(logic [15:0] budget);
    lrrb_pkg::req_t r;
    r.command = lrrb_pkg::CMD_POP; r.data_byte = 8'($urandom); r.level = 3'($urandom);
    r.budget = budget;
    pending_reqs.push_back(r);
  endfunction

  function automatic void queue_record(int unsigned len, logic [2:0] lvl);
    queue_push(8'(len), lvl);
    for (int unsigned i = 1; i < len; i++) queue_push(8'($urandom), 3'($urandom));
  endfunction

  function automatic void queue_random(int unsigned count, int unsigned big_pct);
    int unsigned pick, len;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        len = ($urandom_range(99) < big_pct) ? $urandom_range(40, lrrb_pkg::MAX_RECORD)
                                               : $urandom_range(1, 12);
        queue_record(len, 3'($urandom));
      end else if (pick < 62) begin
        // broken: a length above MAX_RECORD or a zero length
        if ($urandom_range(1))
          queue_push(8'($urandom_range(lrrb_pkg::MAX_RECORD + 1, 255)), 3'($urandom));
        else queue_push(8'd0, 3'($urandom));
      end else if (pick < 80) begin
        queue_pop(16'($urandom_range(lrrb_pkg::MAX_RECORD, 65535)));
      end else if (pick < 90) begin
        queue_pop(16'($urandom));
      end else begin
        queue_pop(16'($urandom_range(0, 70)));
      end
    end
  endfunction

  task automatic write_reg(logic [7:0] idx, logic [7:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload <= '{index: idx, data: value};
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    if (idx == 8'(lrrb_pkg::REG_LEVEL_THRESHOLD)) level_floor = value[2:0];
    else if (idx == 8'(lrrb_pkg::REG_OVERWRITE_OLD)) evict_on_full = value[0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  // Driver: advance to the next request once the current one is taken.
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || req_taken)) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.payload <= pending_reqs.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: predict on accepted requests, then check results.
  always @(posedge clk) begin
    lrrb_pkg::res_t want;
    lrrb_pkg::res_t got;
    cycles++;
    req_taken = in_ch.valid && in_ch.ready;
    if (rst_n && req_taken) predict_request(in_ch.payload);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (expected_results.size() == 0) begin
        $error("unexpected result: out_byte %0d last %0d status %0d",
               got.out_byte, got.last, got.status);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0d, got %0d", want.out_byte, got.out_byte);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    req_taken = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    clear_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: bad lengths, filtering, short records, empty and too-big pops.
    queue_pop(16'hFFFF);
    queue_push(8'd0, 3'd7);
    queue_push(8'd65, 3'd7);
    queue_push(8'd255, 3'd7);
    queue_record(1, 3'd7);
    queue_record(3, 3'd0);
    queue_record(4, 3'd1);
    queue_pop(16'd0);
    queue_pop(16'd1);
    queue_pop(16'd3);
    queue_pop(16'd4);
    queue_record(2, 3'd5);
    queue_pop(16'hFFFF);
    queue_pop(16'hFFFF);
    drain();
    queue_random(5, 0);
    drain();

    // Lowest threshold, sender idling.
    write_reg(8'(lrrb_pkg::REG_LEVEL_THRESHOLD), 8'd0);
    write_reg(CFG_IDX_UNUSED, 8'hFF);
    send_idle_pct = 45;
    queue_random(5, 10);
    drain();

    // Drop new records when full, receiver stalling.
    write_reg(8'(lrrb_pkg::REG_OVERWRITE_OLD), 8'd0);
    send_idle_pct = 0;
    recv_stall_pct = 45;
    queue_random(5, 0);
    drain();

    // Highest threshold, both sides idling.
    write_reg(8'(lrrb_pkg::REG_LEVEL_THRESHOLD), 8'd7);
    write_reg(8'(lrrb_pkg::REG_OVERWRITE_OLD), 8'd1);
    send_idle_pct = 23;
    recv_stall_pct = 23;
    queue_random(5, 0);
    drain();

    write_reg(8'(lrrb_pkg::REG_LEVEL_THRESHOLD), 8'd3);
    write_reg(8'(lrrb_pkg::REG_OVERWRITE_OLD), 8'd0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random(5, 0);
    drain();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
